// File: hdl/assert_macros.svh
// Assertion macros shared by the date difference unit.
// Depends on a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset
`define DD_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in this cycle requires the consequent in the next cycle
`define DD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/dd_pkg.sv
// Shared types, constants and month tables for the date difference unit.
// No dependencies.
package dd_pkg;

  localparam int unsigned DATE_W  = 27;
  localparam int unsigned COUNT_W = 22;
  localparam int unsigned STAGES  = 5;  // stages inside one lane

  localparam logic [DATE_W-1:0] DEFAULT_BEGIN_RST = 27'd15051980;
  localparam logic [DATE_W-1:0] DEFAULT_END_RST   = 27'd7062012;

  // Exact reciprocals: x/10000 for 27-bit x, x/100 for 14-bit x
  localparam logic [27:0] DIV10K_MUL = 28'd219902326;
  localparam int unsigned DIV10K_SH  = 41;
  localparam logic [14:0] DIV100_MUL = 15'd20972;
  localparam int unsigned DIV100_SH  = 21;

  typedef enum logic [0:0] {
    REG_DEFAULT_BEGIN = 1'b0,
    REG_DEFAULT_END   = 1'b1
  } dd_reg_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MONTH = 2'd1,
    ST_BAD_DAY   = 2'd2,
    ST_NEGATIVE  = 2'd3
  } dd_status_t;

  // What one lane reports about its date
  typedef struct packed {
    logic               month_ok;
    logic               day_ok;
    logic [COUNT_W-1:0] serial;
  } dd_date_t;

  // Length of a month in a common year
  function automatic logic [4:0] month_len(input logic [6:0] m);
    logic [4:0] len;
    unique case (m)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
      7'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the months before month m of a common year
  function automatic logic [8:0] days_before_month(input logic [6:0] m);
    logic [8:0] d;
    unique case (m)
      7'd2:    d = 9'd31;
      7'd3:    d = 9'd59;
      7'd4:    d = 9'd90;
      7'd5:    d = 9'd120;
      7'd6:    d = 9'd151;
      7'd7:    d = 9'd181;
      7'd8:    d = 9'd212;
      7'd9:    d = 9'd243;
      7'd10:   d = 9'd273;
      7'd11:   d = 9'd304;
      7'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// File: hdl/dd_lane.sv
// One date lane: default select, decimal split, validity checks, serial day.
// Depends on dd_pkg.
module dd_lane
  import dd_pkg::*;
(
  input  logic              clk,
  input  logic [STAGES-1:0] load,          // per-stage load enable
  input  logic [DATE_W-1:0] date_in,
  input  logic [DATE_W-1:0] default_date,
  output dd_date_t          result
);

  // Stage 1: default select, multiply by reciprocal of 10000
  logic [DATE_W-1:0] sel_date;
  logic [DATE_W-1:0] s1_date;
  logic [54:0]       s1_prod;

  assign sel_date = (date_in == '0) ? default_date : date_in;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      s1_date <= sel_date;
      s1_prod <= 55'(sel_date) * 55'(DIV10K_MUL);
    end
  end

  // Stage 2: DDMM quotient, year remainder, reciprocal of 100 on DDMM
  logic [13:0] q_ddmm;
  logic [13:0] s2_q;
  logic [13:0] s2_year;
  logic [28:0] s2_prod;

  assign q_ddmm = s1_prod[54:DIV10K_SH];

  always_ff @(posedge clk) begin
    if (load[1]) begin
      s2_q    <= q_ddmm;
      s2_year <= 14'(s1_date - 27'(27'(q_ddmm) * 27'd10000));
      s2_prod <= 29'(q_ddmm) * 29'(DIV100_MUL);
    end
  end

  // Stage 3: day and month, reciprocal of 100 on the year
  logic [7:0]  day_c;
  logic [13:0] mon_full;
  logic [7:0]  s3_day;
  logic [6:0]  s3_month;
  logic [13:0] s3_year;
  logic [27:0] s3_prod;

  assign day_c    = s2_prod[28:DIV100_SH];
  assign mon_full = s2_q - 14'(14'(day_c) * 14'd100);

  always_ff @(posedge clk) begin
    if (load[2]) begin
      s3_day   <= day_c;
      s3_month <= mon_full[6:0];
      s3_year  <= s2_year;
      s3_prod  <= 28'(s2_year) * 28'(DIV100_MUL);
    end
  end

  // Stage 4: century split, leap rule, range checks, bulk year days
  logic [6:0]  cent;
  logic [13:0] rem_full;
  logic        rem_zero;
  logic        leap;
  logic [4:0]  lim;
  logic [6:0]  s4_cent;
  logic        s4_rem_zero;
  logic        s4_leap;
  logic        s4_mok;
  logic        s4_dok;
  logic [7:0]  s4_day;
  logic [6:0]  s4_month;
  logic [COUNT_W-1:0] s4_t1;

  assign cent     = s3_prod[27:DIV100_SH];
  assign rem_full = s3_year - 14'(14'(cent) * 14'd100);
  assign rem_zero = (rem_full[6:0] == '0);
  assign leap     = ((s3_year[1:0] == 2'd0) && !rem_zero) || (rem_zero && (cent[1:0] == 2'd0));
  assign lim      = (s3_month == 7'd2 && leap) ? 5'd29 : month_len(s3_month);

  always_ff @(posedge clk) begin
    if (load[3]) begin
      s4_cent     <= cent;
      s4_rem_zero <= rem_zero;
      s4_leap     <= leap;
      s4_mok      <= (s3_month >= 7'd1) && (s3_month <= 7'd12);
      s4_dok      <= (s3_day != '0) && (s3_day <= 8'(lim));
      s4_day      <= s3_day;
      s4_month    <= s3_month;
      s4_t1       <= 22'(s3_year) * 22'd365 + 22'((s3_year + 14'd3) >> 2);
    end
  end

  // Stage 5: century corrections, month offset, day
  logic [COUNT_W-1:0] cent_up;
  logic [COUNT_W-1:0] quad_up;
  logic [COUNT_W-1:0] serial_c;

  assign cent_up  = 22'(s4_cent) + 22'(!s4_rem_zero);
  assign quad_up  = 22'(s4_cent >> 2) + 22'((s4_cent[1:0] != 2'd0) || !s4_rem_zero);
  assign serial_c = s4_t1 - cent_up + quad_up + 22'(days_before_month(s4_month))
                    + 22'(s4_day) + 22'((s4_month > 7'd2) && s4_leap);

  always_ff @(posedge clk) begin
    if (load[4]) begin
      result.month_ok <= s4_mok;
      result.day_ok   <= s4_dok;
      result.serial   <= serial_c;
    end
  end

endmodule

// File: hdl/dd_merge.sv
// Merge stage: combines both lanes into status and day count, output register.
// Depends on dd_pkg.
module dd_merge
  import dd_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  dd_date_t           begin_res,
  input  dd_date_t           end_res,
  output logic [COUNT_W-1:0] day_count,
  output dd_status_t         status
);

  logic [COUNT_W-1:0] count_next;
  dd_status_t         status_next;

  // Month check first, then day check, then sign of the period
  always_comb begin
    count_next  = '0;
    status_next = ST_OK;
    priority if (!begin_res.month_ok || !end_res.month_ok) begin
      status_next = ST_BAD_MONTH;
    end else if (!begin_res.day_ok || !end_res.day_ok) begin
      status_next = ST_BAD_DAY;
    end else if (end_res.serial < begin_res.serial) begin
      status_next = ST_NEGATIVE;
    end else begin
      count_next = end_res.serial - begin_res.serial;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      day_count <= count_next;
      status    <= status_next;
    end
  end

endmodule

// File: hdl/date_difference_days_unit.sv
// Days between two DDMMYYYY dates: top level with handshake and registers.
// Depends on dd_pkg, dd_lane, dd_merge and assert_macros.svh.
// Path from input transaction to result valid: 5 lane stages + merge.
// Throughput: one transaction per cycle; each stage stalls only when it holds
// data and the stage after it cannot take it, so bubbles close up under stall.
// Reset clears all valid flags and loads the default dates 15051980 / 7062012.
`include "assert_macros.svh"

module date_difference_days_unit
  import dd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration write port
  input  logic              cfg_wr_en,
  input  logic [0:0]        cfg_index,
  input  logic [DATE_W-1:0] cfg_data,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [55:0]       s_tdata,   // [26:0] begin_date, [53:27] end_date, zero fill
  // output stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata    // [21:0] day_count, [23:22] status
);

  // Default date registers
  logic [DATE_W-1:0] default_begin;
  logic [DATE_W-1:0] default_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_begin <= DEFAULT_BEGIN_RST;
      default_end   <= DEFAULT_END_RST;
    end else if (cfg_wr_en) begin
      unique case (dd_reg_t'(cfg_index))
        REG_DEFAULT_BEGIN: default_begin <= cfg_data;
        REG_DEFAULT_END:   default_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline occupancy and per-stage load enables
  logic [STAGES-1:0] vld;
  logic [STAGES:0]   load;   // load[STAGES] drives the output register

  always_comb begin
    load[STAGES] = !m_tvalid || m_tready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      load[k] = !vld[k] || load[k+1];
    end
  end

  assign s_tready = load[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (load[k]) begin
          vld[k] <= vld[k-1];
        end
      end
      if (load[STAGES]) begin
        m_tvalid <= vld[STAGES-1];
      end
    end
  end

  // Two date lanes
  dd_date_t begin_res;
  dd_date_t end_res;

  dd_lane u_lane_begin (
    .clk          (clk),
    .load         (load[STAGES-1:0]),
    .date_in      (s_tdata[DATE_W-1:0]),
    .default_date (default_begin),
    .result       (begin_res)
  );

  dd_lane u_lane_end (
    .clk          (clk),
    .load         (load[STAGES-1:0]),
    .date_in      (s_tdata[2*DATE_W-1:DATE_W]),
    .default_date (default_end),
    .result       (end_res)
  );

  // Merge and output register
  logic [COUNT_W-1:0] day_count;
  dd_status_t         status;

  dd_merge u_merge (
    .clk       (clk),
    .load      (load[STAGES]),
    .begin_res (begin_res),
    .end_res   (end_res),
    .day_count (day_count),
    .status    (status)
  );

  assign m_tdata = {status, day_count};

  // Checks
  `DD_ASSERT(a_count_zero_on_error, !m_tvalid || status == ST_OK || day_count == '0, "day count not zero on error status")
  `DD_ASSERT_NEXT(a_last_stage_drains, vld[STAGES-1] && load[STAGES], m_tvalid, "lane result lost before output")
  `DD_ASSERT(a_stall_only_when_full, s_tready || ((&vld) && m_tvalid && !m_tready), "input stalled with a free stage")

endmodule
